@@ rtl/core/nca_pkg.sv @@
`default_nettype none

package nca_pkg;

  // Field widths of one command word and one result word
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned LAYER_W = 4;
  localparam int unsigned KEY_W   = LAYER_W + NOTE_W;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned STAT_W  = 2;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic load;  // capture the incoming command word
    logic exec;  // search the bindings and update the pool
  } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/nca_ctrl.sv @@
`default_nettype none

module nca_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output nca_pkg::ctrl_t     ctrl_o
);
  import nca_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // Sequence: accept, execute, then signal the result with done_o for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE, S_RESP: begin
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
          done_q <= 1'b0;
        end
        S_EXEC: begin
          state_q <= S_RESP;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy        = busy_q;
  assign done_o      = done_q;
  assign ctrl_o.load = start & ~busy_q;
  assign ctrl_o.exec = (state_q == S_EXEC);

endmodule

`default_nettype wire

@@ rtl/core/nca_datapath.sv @@
`default_nettype none

module nca_datapath #(
  parameter int unsigned NUM_CHANNELS = 15,
  parameter int unsigned NUM_LAYERS   = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire nca_pkg::ctrl_t                 ctrl_i,
  input  wire logic [nca_pkg::CMD_W-1:0]      command_i,
  input  wire logic [nca_pkg::NOTE_W-1:0]     note_i,
  input  wire logic [nca_pkg::LAYER_W-1:0]    layer_i,
  output logic      [nca_pkg::CH_W-1:0]       channel_o,
  output logic      [nca_pkg::STAT_W-1:0]     status_o
);
  import nca_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Captured command word
  cmd_e               cmd_q;
  logic [KEY_W-1:0]   key_q;

  // Pool state
  logic [CH_W-1:0]    stack_q [NUM_CHANNELS];
  logic [CH_W-1:0]    stack_d [NUM_CHANNELS];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [KEY_W-1:0]   owner_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_q, valid_d;

  // Result registers
  logic [CH_W-1:0]    chan_q, chan_d;
  status_e            status_q, status_d;

  // Search and stack access
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CH_W-1:0]    top_ch;
  logic [CH_W-1:0]    top_m1;
  logic               top_ok;
  logic               layer_bad;
  logic               bind_en;

  // Capture the command word on acceptance
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= {layer_i, note_i};
    end
  end

  // Compare the key against every binding; the lowest channel wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (valid_q[i] && (owner_q[i] == key_q)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign cnt_m1    = count_q - 1'b1;
  assign top_ch    = stack_q[cnt_m1[IDX_W-1:0]];
  assign top_m1    = top_ch - 1'b1;
  assign top_ok    = (top_ch != '0) && (CNT_W'(top_ch) <= CNT_W'(NUM_CHANNELS));
  assign layer_bad = (8'(key_q[KEY_W-1:NOTE_W]) >= 8'(NUM_LAYERS));

  // Work out the next pool state and the result
  always_comb begin
    stack_d  = stack_q;
    count_d  = count_q;
    valid_d  = valid_q;
    chan_d   = chan_q;
    status_d = status_q;
    bind_en  = 1'b0;
    if (ctrl_i.exec) begin
      chan_d   = '0;
      status_d = ST_OK;
      priority if (cmd_q == CMD_RESET) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          stack_d[i] = CH_W'(NUM_CHANNELS - i);
        end
        count_d = CNT_W'(NUM_CHANNELS);
        valid_d = '0;
      end else if (layer_bad) begin
        status_d = ST_MISS;
      end else if (cmd_q == CMD_ALLOC) begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = cnt_m1;
          // drop a duplicate binding; its channel stays out of the pool
          if (hit) begin
            valid_d[hit_idx] = 1'b0;
            status_d         = ST_DUP;
          end
          if (top_ok) begin
            valid_d[top_m1[IDX_W-1:0]] = 1'b1;
            bind_en                    = 1'b1;
          end
          chan_d = top_ch;
        end
      end else begin
        if (!hit) begin
          status_d = ST_MISS;
        end else begin
          chan_d = CH_W'(hit_idx) + 1'b1;
          if (cmd_q == CMD_RELEASE) begin
            valid_d[hit_idx] = 1'b0;
            if (count_q < CNT_W'(NUM_CHANNELS)) begin
              stack_d[count_q[IDX_W-1:0]] = CH_W'(hit_idx) + 1'b1;
              count_d                     = count_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // Hold the pool and the bindings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stack_q[i] <= CH_W'(NUM_CHANNELS - i);
      end
      count_q <= CNT_W'(NUM_CHANNELS);
      valid_q <= '0;
    end else begin
      stack_q <= stack_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Bind the key to the popped channel
  always_ff @(posedge clk_i) begin
    if (bind_en) begin
      owner_q[top_m1[IDX_W-1:0]] <= key_q;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    chan_q   <= chan_d;
    status_q <= status_d;
  end

  assign channel_o = chan_q;
  assign status_o  = status_q;

endmodule

`default_nettype wire

@@ rtl/core/note_channel_allocator_core.sv @@
`default_nettype none

// Per-note channel allocator. Channels 1 to NUM_CHANNELS sit on a last-in
// first-out free stack; an allocate pops one and binds it to the key
// {layer, note}, a release searches the bindings and pushes the channel back,
// a lookup only searches, and a reset command reloads the pool with channel 1
// on top. A command word is taken when start is high and busy is low. Each
// word is executed with busy high, while all bindings are compared in
// parallel and the stack is updated; its result is then shown with done_o
// high. busy is low while the result is shown, so a new word may be started
// then. done_o is high for exactly one cycle and cannot be held off, and
// channel_o and status_o hold the result until the next word executes: sample
// it when done_o is high. A channel 0 result means none; status 1 is pool
// empty, 2 a duplicate key rebound (the old channel stays out of the pool
// until a reset command), 3 key not found or layer out of range.
module note_channel_allocator_core #(
  parameter int unsigned NUM_CHANNELS = 15,
  parameter int unsigned NUM_LAYERS   = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [nca_pkg::CMD_W-1:0]    command_i,
  input  wire logic [nca_pkg::NOTE_W-1:0]   note_i,
  input  wire logic [nca_pkg::LAYER_W-1:0]  layer_i,
  output logic                              done_o,
  output logic      [nca_pkg::CH_W-1:0]     channel_o,
  output logic      [nca_pkg::STAT_W-1:0]   status_o
);
  import nca_pkg::*;

  ctrl_t ctrl;

  nca_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  nca_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_LAYERS   (NUM_LAYERS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .command_i (command_i),
    .note_i    (note_i),
    .layer_i   (layer_i),
    .channel_o (channel_o),
    .status_o  (status_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted word is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not enter execution");

  // Execution is followed directly by its result, with busy low
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("execution not followed by a result");

  // Empty pool and miss results carry no channel
  a_no_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY || status_o == ST_MISS)) |-> (channel_o == '0))
    else $error("empty or miss result carries a channel");

  // A rebound channel lies inside the pool
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_DUP)) |->
      (channel_o != '0 && 32'(channel_o) <= NUM_CHANNELS))
    else $error("rebound channel outside the pool");
`endif

endmodule

`default_nettype wire
